// File: design/conv2d_point_engine_top_macros.svh
// assertion macros for the point engine checker
`ifndef CONV2D_POINT_ENGINE_TOP_MACROS_SVH
`define CONV2D_POINT_ENGINE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define CPE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed");
// implication checked in the next cycle
`define CPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: design/cpe_pkg.sv
// ----------------------------------------------------------------------------
// cpe_pkg
// shared types and constants of the convolution point engine
// ----------------------------------------------------------------------------
package cpe_pkg;
    typedef enum logic [1:0] {
        OP_LOAD_SAMPLE = 2'd0,
        OP_LOAD_WEIGHT = 2'd1,
        OP_LOAD_BIAS   = 2'd2,
        OP_COMPUTE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RELU  = 2'd1,
        ACT_CLAMP = 2'd2,
        ACT_RELU6 = 2'd3
    } act_t;

    localparam logic [2:0] REG_IN_CH    = 3'd0;
    localparam logic [2:0] REG_OUT_CH   = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_WIDTH    = 3'd3;
    localparam logic [2:0] REG_STRIDE   = 3'd4;
    localparam logic [2:0] REG_PAD      = 3'd5;
    localparam logic [2:0] REG_DILATION = 3'd6;
    localparam logic [2:0] REG_ACT      = 3'd7;

    localparam int ACC_W = 40;

    // configuration set seen by the sequencer
    typedef struct packed {
        logic [4:0] in_channels;
        logic [4:0] out_channels;
        logic [5:0] in_height;
        logic [5:0] in_width;
        logic [2:0] stride;
        logic [2:0] pad;
        logic [2:0] dilation;
        act_t       activation;
    } cfg_t;

    // post processing: bias, activation, rounding, saturation
    function automatic logic [16:0] cpe_finish(input logic signed [ACC_W-1:0] acc,
                                               input logic signed [31:0] bias,
                                               input act_t act);
        logic signed [41:0] t;
        logic signed [33:0] r;
        logic [16:0] res;
        t = 42'(acc) + 42'(bias);
        case (act)
            ACT_RELU: begin
                if (t < 0) t = '0;
            end
            ACT_CLAMP: begin
                if (t < -42'sd65536) t = -42'sd65536;
                if (t > 42'sd65536) t = 42'sd65536;
            end
            ACT_RELU6: begin
                if (t < 0) t = '0;
                if (t > 42'sd393216) t = 42'sd393216;
            end
            default: begin
            end
        endcase
        t = t + 42'sd128;
        r = 34'(t >>> 8);
        if (r > 34'sd32767) res = {1'b1, 16'h7fff};
        else if (r < -34'sd32768) res = {1'b1, 16'h8000};
        else res = {1'b0, r[15:0]};
        return res;
    endfunction
endpackage

// File: design/cpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// cpe_cfg_regs
// apb register file holding the convolution configuration
// ----------------------------------------------------------------------------
module cpe_cfg_regs (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output cpe_pkg::cfg_t cfg
);
    import cpe_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] idx;
    logic wr;

    assign pready = 1'b1;
    assign idx = paddr[4:2];
    assign wr = psel && penable && pwrite;
    assign cfg = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_channels  <= 5'd1;
            cfg_reg.out_channels <= 5'd1;
            cfg_reg.in_height    <= 6'd32;
            cfg_reg.in_width     <= 6'd32;
            cfg_reg.stride       <= 3'd1;
            cfg_reg.pad          <= 3'd0;
            cfg_reg.dilation     <= 3'd1;
            cfg_reg.activation   <= ACT_NONE;
        end else if (wr) begin
            case (idx)
                REG_IN_CH:    cfg_reg.in_channels  <= pwdata[4:0];
                REG_OUT_CH:   cfg_reg.out_channels <= pwdata[4:0];
                REG_HEIGHT:   cfg_reg.in_height    <= pwdata[5:0];
                REG_WIDTH:    cfg_reg.in_width     <= pwdata[5:0];
                REG_STRIDE:   cfg_reg.stride       <= pwdata[2:0];
                REG_PAD:      cfg_reg.pad          <= pwdata[2:0];
                REG_DILATION: cfg_reg.dilation     <= pwdata[2:0];
                default:      cfg_reg.activation   <= act_t'(pwdata[1:0]);
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_IN_CH:    prdata = 32'(cfg_reg.in_channels);
            REG_OUT_CH:   prdata = 32'(cfg_reg.out_channels);
            REG_HEIGHT:   prdata = 32'(cfg_reg.in_height);
            REG_WIDTH:    prdata = 32'(cfg_reg.in_width);
            REG_STRIDE:   prdata = 32'(cfg_reg.stride);
            REG_PAD:      prdata = 32'(cfg_reg.pad);
            REG_DILATION: prdata = 32'(cfg_reg.dilation);
            default:      prdata = 32'(cfg_reg.activation);
        endcase
    end
endmodule

// File: design/cpe_stores.sv
// ----------------------------------------------------------------------------
// cpe_stores
// feature, weight and bias memories, registered reads
// ----------------------------------------------------------------------------
module cpe_stores #(
    parameter int FEAT_DEPTH = 16384,
    parameter int WGT_DEPTH  = 2304,
    parameter int BIAS_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          feat_we,
    input  logic [$clog2(FEAT_DEPTH)-1:0] feat_waddr,
    input  logic [15:0]                   feat_wdata,
    input  logic [$clog2(FEAT_DEPTH)-1:0] feat_raddr,
    output logic [15:0]                   feat_rdata,
    input  logic                          wgt_we,
    input  logic [$clog2(WGT_DEPTH)-1:0]  wgt_waddr,
    input  logic [15:0]                   wgt_wdata,
    input  logic [$clog2(WGT_DEPTH)-1:0]  wgt_raddr,
    output logic [15:0]                   wgt_rdata,
    input  logic                          bias_we,
    input  logic [$clog2(BIAS_DEPTH)-1:0] bias_waddr,
    input  logic [31:0]                   bias_wdata,
    input  logic [$clog2(BIAS_DEPTH)-1:0] bias_raddr,
    output logic [31:0]                   bias_rdata
);
    logic [15:0] feat_mem [FEAT_DEPTH];
    logic [15:0] wgt_mem  [WGT_DEPTH];
    logic [31:0] bias_mem [BIAS_DEPTH];

    // feature map store
    always_ff @(posedge aclk) begin
        if (feat_we) feat_mem[feat_waddr] <= feat_wdata;
        feat_rdata <= feat_mem[feat_raddr];
    end

    // weight store
    always_ff @(posedge aclk) begin
        if (wgt_we) wgt_mem[wgt_waddr] <= wgt_wdata;
        wgt_rdata <= wgt_mem[wgt_raddr];
    end

    // bias store
    always_ff @(posedge aclk) begin
        if (bias_we) bias_mem[bias_waddr] <= bias_wdata;
        bias_rdata <= bias_mem[bias_raddr];
    end
endmodule

// File: design/conv2d_point_engine_top.sv
// ----------------------------------------------------------------------------
// conv2d_point_engine_top
// direct 2d convolution, one output point per compute word
// ----------------------------------------------------------------------------
// channel   dir  handshake        contents
// s_axis    in   tvalid/tready    opcode, address, value, out_channel/row/col
// m_axis    out  tvalid/tready    result, overflow
// apb       in   psel/penable     eight configuration registers
// a load word is written to its store as it is taken; a compute word steps through
// its taps over every input channel (in_channels capped at the maximum) and kernel
// position, one read port per store feeding the single multiply-accumulate.
// the input reopens in the cycle the result becomes valid.
// reset is synchronous active low and clears control state, not the stores.
// the result sits in an output register; the next word is taken while it waits,
// but a compute word is held until the output register is free.
module conv2d_point_engine_top #(
    parameter int MAX_IN_CHANNELS  = 16,
    parameter int MAX_OUT_CHANNELS = 16,
    parameter int MAX_SIZE         = 32,
    parameter int KER_ROWS         = 3,
    parameter int KER_COLS         = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] opcode, [15:2] address, [47:16] value, [51:48] out_channel,
    // [56:52] out_row, [61:57] out_col
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] result, [16] overflow
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpe_pkg::*;

    localparam int SZ_W = $clog2(MAX_SIZE);
    localparam int IC_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OC_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int FEAT_DEPTH = MAX_IN_CHANNELS * MAX_SIZE * MAX_SIZE;
    localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KER_ROWS * KER_COLS;
    localparam int FA_W = $clog2(FEAT_DEPTH);
    localparam int WA_W = $clog2(WGT_DEPTH);
    localparam int KH_W = (KER_ROWS > 1) ? $clog2(KER_ROWS) : 1;
    localparam int KW_W = (KER_COLS > 1) ? $clog2(KER_COLS) : 1;
    localparam int TAPS = MAX_IN_CHANNELS * KER_ROWS * KER_COLS;

    typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_BIAS, ST_DONE} state_t;

    cfg_t cfg;
    cpe_cfg_regs u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    // input field split
    opcode_t     in_op;
    logic [13:0] in_addr;
    logic [31:0] in_val;
    logic [3:0]  in_oc;
    logic [4:0]  in_row, in_col;
    assign in_op   = opcode_t'(s_axis_tdata[1:0]);
    assign in_addr = s_axis_tdata[15:2];
    assign in_val  = s_axis_tdata[47:16];
    assign in_oc   = s_axis_tdata[51:48];
    assign in_row  = s_axis_tdata[56:52];
    assign in_col  = s_axis_tdata[61:57];

    state_t state_reg;
    logic out_valid_reg;
    logic [16:0] out_data_reg;
    logic in_fire, out_fire;

    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           (in_op != OP_COMPUTE || !out_valid_reg || m_axis_tready);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_data_reg};

    // store write side, loads decoded straight from the input word
    logic feat_we, wgt_we, bias_we;
    assign feat_we = in_fire && in_op == OP_LOAD_SAMPLE && 32'(in_addr) < FEAT_DEPTH;
    assign wgt_we  = in_fire && in_op == OP_LOAD_WEIGHT && 32'(in_addr) < WGT_DEPTH;
    assign bias_we = in_fire && in_op == OP_LOAD_BIAS && 32'(in_addr) < MAX_OUT_CHANNELS;

    logic [FA_W-1:0] fa;
    logic [WA_W-1:0] wa;
    logic [15:0] feat_rdata, wgt_rdata;
    logic [31:0] bias_rdata;
    logic [OC_W-1:0] oc_reg;

    cpe_stores #(
        .FEAT_DEPTH(FEAT_DEPTH), .WGT_DEPTH(WGT_DEPTH), .BIAS_DEPTH(MAX_OUT_CHANNELS)
    ) u_stores (
        .aclk(aclk),
        .feat_we(feat_we), .feat_waddr(FA_W'(in_addr)), .feat_wdata(in_val[15:0]),
        .feat_raddr(fa), .feat_rdata(feat_rdata),
        .wgt_we(wgt_we), .wgt_waddr(WA_W'(in_addr)), .wgt_wdata(in_val[15:0]),
        .wgt_raddr(wa), .wgt_rdata(wgt_rdata),
        .bias_we(bias_we), .bias_waddr(OC_W'(in_addr)), .bias_wdata(in_val),
        .bias_raddr(oc_reg), .bias_rdata(bias_rdata)
    );

    // tap sequencer registers
    logic [IC_W-1:0] ic_reg;
    logic [KH_W-1:0] ky_reg;
    logic [KW_W-1:0] kx_reg;
    logic [IC_W:0]   nic_reg;
    logic signed [10:0] ybase_reg, xbase_reg, y_reg, x_reg;
    logic [8:0] hlim_reg, wlim_reg;
    logic [$clog2(TAPS+1)-1:0] cnt_reg;
    logic tap_ok_reg, unused_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0] prod_reg;
    logic prod_ok_reg;

    // tap validity and addresses for the current counters
    logic tap_ok;
    assign tap_ok = (y_reg >= 0) && (x_reg >= 0) && (32'(y_reg) < 32'(hlim_reg)) &&
                    (32'(x_reg) < 32'(wlim_reg));
    assign fa = FA_W'((32'(ic_reg) * MAX_SIZE + 32'(y_reg[SZ_W-1:0])) * MAX_SIZE +
                      32'(x_reg[SZ_W-1:0]));
    assign wa = WA_W'(((32'(oc_reg) * MAX_IN_CHANNELS + 32'(ic_reg)) * KER_ROWS +
                       32'(ky_reg)) * KER_COLS + 32'(kx_reg));

    logic last_tap;
    assign last_tap = (32'(kx_reg) == KER_COLS - 1) && (32'(ky_reg) == KER_ROWS - 1) &&
                      (32'(ic_reg) + 1 >= 32'(nic_reg));

    logic [16:0] fin;
    assign fin = cpe_finish(acc_reg, bias_rdata, cfg.activation);

    // sequencer, mac and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tap_ok_reg <= 1'b0;
            prod_ok_reg <= 1'b0;
        end else begin
            if (out_fire) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire && in_op == OP_COMPUTE) begin
                        oc_reg <= OC_W'(in_oc);
                        unused_reg <= (5'(in_oc) >= cfg.out_channels) ||
                                      (32'(in_oc) >= MAX_OUT_CHANNELS);
                        nic_reg <= (32'(cfg.in_channels) > MAX_IN_CHANNELS) ?
                                   (IC_W+1)'(MAX_IN_CHANNELS) : (IC_W+1)'(cfg.in_channels);
                        hlim_reg <= (32'(cfg.in_height) > MAX_SIZE) ?
                                    9'(MAX_SIZE) : 9'(cfg.in_height);
                        wlim_reg <= (32'(cfg.in_width) > MAX_SIZE) ?
                                    9'(MAX_SIZE) : 9'(cfg.in_width);
                        ybase_reg <= 11'(in_row * cfg.stride) - 11'(cfg.pad);
                        xbase_reg <= 11'(in_col * cfg.stride) - 11'(cfg.pad);
                        y_reg <= 11'(in_row * cfg.stride) - 11'(cfg.pad);
                        x_reg <= 11'(in_col * cfg.stride) - 11'(cfg.pad);
                        ic_reg <= '0; ky_reg <= '0; kx_reg <= '0;
                        acc_reg <= '0;
                        tap_ok_reg <= 1'b0;
                        state_reg <= (cfg.in_channels == 5'd0) ? ST_DRAIN : ST_RUN;
                    end
                end
                ST_RUN: begin
                    // step kx, then ky, then ic
                    tap_ok_reg <= tap_ok;
                    if (32'(kx_reg) == KER_COLS - 1) begin
                        kx_reg <= '0;
                        x_reg <= xbase_reg;
                        if (32'(ky_reg) == KER_ROWS - 1) begin
                            ky_reg <= '0;
                            y_reg <= ybase_reg;
                            ic_reg <= ic_reg + 1'b1;
                        end else begin
                            ky_reg <= ky_reg + 1'b1;
                            y_reg <= y_reg + 11'(cfg.dilation);
                        end
                    end else begin
                        kx_reg <= kx_reg + 1'b1;
                        x_reg <= x_reg + 11'(cfg.dilation);
                    end
                    if (last_tap) state_reg <= ST_DRAIN;
                    cnt_reg <= '0;
                end
                ST_DRAIN: begin
                    tap_ok_reg <= 1'b0;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2) state_reg <= ST_BIAS;
                end
                ST_BIAS: state_reg <= ST_DONE;
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    out_data_reg <= unused_reg ? 17'd0 : fin;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            // mac pipeline: read data, product, accumulate
            prod_ok_reg <= tap_ok_reg;
            prod_reg <= $signed(feat_rdata) * $signed(wgt_rdata);
            if (prod_ok_reg && state_reg != ST_IDLE) acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end
endmodule

// File: design/cpe_checker.sv
// ----------------------------------------------------------------------------
// cpe_checker
// port level checks of the convolution point engine
// ----------------------------------------------------------------------------
`include "conv2d_point_engine_top_macros.svh"
module cpe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import cpe_pkg::*;

    logic in_compute, out_wait, out_sat, sat_value;
    assign in_compute = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_COMPUTE;
    assign out_wait = m_axis_tvalid && !m_axis_tready;
    assign out_sat = m_axis_tvalid && m_axis_tdata[16];
    assign sat_value = m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000;

    // a stalled result word holds
    `CPE_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
    // padding bits of the result are zero
    `CPE_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[23:17] == 7'd0)
    // a compute word taken while no result is pending produces no result in the next cycle
    `CPE_ASSERT_NEXT(a_no_fast, in_compute && !m_axis_tvalid, !m_axis_tvalid)
    // engine busy right after taking a compute word
    `CPE_ASSERT_NEXT(a_busy, in_compute, !s_axis_tready)
    // the overflow flag only comes with a saturated value
    `CPE_ASSERT_IMPL(a_ovf, out_sat, sat_value)
endmodule

bind conv2d_point_engine_top cpe_checker u_cpe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
